/* rtl/core/tppc_pkg.sv */
// ----------------------------------------------------------------------------
// Timer prescaler/period calculator package
// Widths, register indexes and shared types for the calculator core.
// ----------------------------------------------------------------------------
package tppc_pkg;

    localparam int CLOCK_W   = 32;
    localparam int FREQ_W    = 32;
    localparam int LIMIT_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Dividends never exceed the clock width; divisors are a 17 x 32 product.
    localparam int DIVIDEND_W = CLOCK_W;
    localparam int DIVISOR_W  = (LIMIT_W + 1) + FREQ_W;
    localparam int STEP_CNT_W = $clog2(DIVIDEND_W);

    localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET        = 32'd80000000;
    localparam logic [LIMIT_W-1:0] CLOCK_DIVIDER_RESET   = 16'd0;
    localparam logic [LIMIT_W-1:0] PRESCALER_LIMIT_RESET = 16'hFFFF;
    localparam logic [LIMIT_W-1:0] PERIOD_LIMIT_RESET    = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLOCK_HZ        = 2'd0,
        CFG_CLOCK_DIVIDER   = 2'd1,
        CFG_PRESCALER_LIMIT = 2'd2,
        CFG_PERIOD_LIMIT    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

endpackage

/* rtl/core/tppc_divider.sv */
// ----------------------------------------------------------------------------
// Shared restoring divider
// Computes an unsigned quotient one bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module tppc_divider
    import tppc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  div_req_t              req,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    div_state_t            state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});

        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;

        case (state_reg)
            DIV_IDLE: begin
                if (req.start) begin
                    quo_next   = req.dividend;
                    rem_next   = '0;
                    dsr_next   = req.divisor;
                    cnt_next   = '0;
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN: begin
                rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(DIVIDEND_W - 1)) begin
                    done_next  = 1'b1;
                    state_next = DIV_IDLE;
                end
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/timer_prescaler_period_calc.sv */
// ----------------------------------------------------------------------------
// Timer prescaler and period calculator
// Each result takes three 32-step passes through the shared divider; two
// when the period cannot be reached and none for a zero frequency. A new
// request is accepted only when idle, after the last result has moved to
// the output register. Synchronous active-low reset restores defaults.
// ----------------------------------------------------------------------------
module timer_prescaler_period_calc
    import tppc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FREQ_W-1:0]     s_target_frequency,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_ok,
    output logic [LIMIT_W-1:0]    m_prescaler_value,
    output logic [LIMIT_W-1:0]    m_period_value
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE,
        ST_MUL1,
        ST_GO1,
        ST_DIV1,
        ST_MUL2,
        ST_GO2,
        ST_DIV2,
        ST_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [CLOCK_W-1:0]    clock_hz_reg, clock_hz_next;
    logic [LIMIT_W-1:0]    clock_div_reg, clock_div_next;
    logic [LIMIT_W-1:0]    presc_lim_reg, presc_lim_next;
    logic [LIMIT_W-1:0]    period_lim_reg, period_lim_next;
    logic [FREQ_W-1:0]     freq_reg, freq_next;
    logic [CLOCK_W-1:0]    base_reg, base_next;
    logic [DIVISOR_W-1:0]  prod_reg, prod_next;
    logic                  ok_reg, ok_next;
    logic [LIMIT_W-1:0]    presc_reg, presc_next;
    logic [LIMIT_W-1:0]    per_reg, per_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_ok_reg, m_ok_next;
    logic [LIMIT_W-1:0]    m_presc_reg, m_presc_next;
    logic [LIMIT_W-1:0]    m_per_reg, m_per_next;

    logic [LIMIT_W:0]      mul_a;
    div_req_t              div_req;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;

    tppc_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = base_reg;
        div_req.divisor  = prod_reg;
        case (state_reg)
            ST_IDLE: begin
                div_req.start    = s_valid && (s_target_frequency != '0);
                div_req.dividend = clock_hz_reg;
                div_req.divisor  = DIVISOR_W'({1'b0, clock_div_reg} + 1'b1);
            end
            ST_GO1, ST_GO2: begin
                div_req.start = 1'b1;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (state_reg == ST_MUL1) begin
            mul_a = {1'b0, period_lim_reg} + 1'b1;
        end else begin
            mul_a = {1'b0, presc_reg} + 1'b1;
        end
    end

    always_comb begin
        state_next      = state_reg;
        clock_hz_next   = clock_hz_reg;
        clock_div_next  = clock_div_reg;
        presc_lim_next  = presc_lim_reg;
        period_lim_next = period_lim_reg;
        freq_next       = freq_reg;
        base_next       = base_reg;
        prod_next       = prod_reg;
        ok_next         = ok_reg;
        presc_next      = presc_reg;
        per_next        = per_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_ok_next       = m_ok_reg;
        m_presc_next    = m_presc_reg;
        m_per_next      = m_per_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_CLOCK_HZ:        clock_hz_next   = cfg_wdata[CLOCK_W-1:0];
                CFG_CLOCK_DIVIDER:   clock_div_next  = cfg_wdata[LIMIT_W-1:0];
                CFG_PRESCALER_LIMIT: presc_lim_next  = cfg_wdata[LIMIT_W-1:0];
                CFG_PERIOD_LIMIT:    period_lim_next = cfg_wdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    freq_next = s_target_frequency;
                    if (s_target_frequency == '0) begin
                        ok_next    = 1'b0;
                        presc_next = '0;
                        per_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        ok_next    = 1'b1;
                        state_next = ST_BASE;
                    end
                end
            end
            ST_BASE: begin
                if (div_done) begin
                    base_next  = div_quo;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1, ST_MUL2: begin
                prod_next  = DIVISOR_W'(freq_reg) * DIVISOR_W'(mul_a);
                state_next = (state_reg == ST_MUL1) ? ST_GO1 : ST_GO2;
            end
            ST_GO1: begin
                state_next = ST_DIV1;
            end
            ST_DIV1: begin
                if (div_done) begin
                    if (div_quo <= DIVIDEND_W'(presc_lim_reg)) begin
                        presc_next = div_quo[LIMIT_W-1:0];
                        state_next = ST_MUL2;
                    end else begin
                        presc_next = presc_lim_reg;
                        per_next   = period_lim_reg;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_GO2: begin
                state_next = ST_DIV2;
            end
            ST_DIV2: begin
                if (div_done) begin
                    per_next   = div_quo[LIMIT_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = ok_reg;
                    m_presc_next = presc_reg;
                    m_per_next   = per_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            clock_hz_reg   <= CLOCK_HZ_RESET;
            clock_div_reg  <= CLOCK_DIVIDER_RESET;
            presc_lim_reg  <= PRESCALER_LIMIT_RESET;
            period_lim_reg <= PERIOD_LIMIT_RESET;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            clock_hz_reg   <= clock_hz_next;
            clock_div_reg  <= clock_div_next;
            presc_lim_reg  <= presc_lim_next;
            period_lim_reg <= period_lim_next;
        end
        freq_reg    <= freq_next;
        base_reg    <= base_next;
        prod_reg    <= prod_next;
        ok_reg      <= ok_next;
        presc_reg   <= presc_next;
        per_reg     <= per_next;
        m_ok_reg    <= m_ok_next;
        m_presc_reg <= m_presc_next;
        m_per_reg   <= m_per_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_ok              = m_ok_reg;
    assign m_prescaler_value = m_presc_reg;
    assign m_period_value    = m_per_reg;

endmodule

/* sim/timer_setting_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer setting checker
// Follows the configuration writes and computes the expected prescaler and
// period for every accepted frequency request, then compares each returned
// transaction field by field, in order, against the oldest expected setting.
// ----------------------------------------------------------------------------
module timer_setting_checker
    import tppc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [FREQ_W-1:0]     s_target_frequency,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_ok,
    input  logic [LIMIT_W-1:0]    m_prescaler_value,
    input  logic [LIMIT_W-1:0]    m_period_value,
    output int                    failure_count,
    output int                    pending_settings
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic               ok;
        logic [LIMIT_W-1:0] prescaler;
        logic [LIMIT_W-1:0] period;
    } timer_setting_t;

    logic [CLOCK_W-1:0] clock_hz_q;
    logic [LIMIT_W-1:0] clock_divider_q;
    logic [LIMIT_W-1:0] prescaler_limit_q;
    logic [LIMIT_W-1:0] period_limit_q;

    timer_setting_t expected_settings [$];

    function automatic timer_setting_t compute_timer_setting(input logic [FREQ_W-1:0] freq);
        logic [63:0] base_hz;
        logic [63:0] min_prescaler;
        logic [63:0] period_wide;
        timer_setting_t setting;
        setting = '0;
        if (freq != '0) begin
            base_hz = {32'd0, clock_hz_q};
            base_hz = base_hz / ({48'd0, clock_divider_q} + 64'd1);
            min_prescaler = base_hz / (({48'd0, period_limit_q} + 64'd1) * {32'd0, freq});
            setting.ok = 1'b1;
            if (min_prescaler <= {48'd0, prescaler_limit_q}) begin
                period_wide = base_hz / ((min_prescaler + 64'd1) * {32'd0, freq});
                setting.prescaler = min_prescaler[LIMIT_W-1:0];
                setting.period = period_wide[LIMIT_W-1:0];
            end else begin
                setting.prescaler = prescaler_limit_q;
                setting.period = period_limit_q;
            end
        end
        return setting;
    endfunction

    always @(posedge aclk) begin : monitor
        timer_setting_t expected;
        if (!aresetn) begin
            clock_hz_q = CLOCK_HZ_RESET;
            clock_divider_q = CLOCK_DIVIDER_RESET;
            prescaler_limit_q = PRESCALER_LIMIT_RESET;
            period_limit_q = PERIOD_LIMIT_RESET;
            expected_settings.delete();
            failure_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_settings.push_back(compute_timer_setting(s_target_frequency));
            end
            if (m_valid && m_ready) begin
                if (expected_settings.size() == 0) begin
                    failure_count++;
                    if (failure_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected transaction ok=%0d prescaler=%0d period=%0d",
                                 $time, m_ok, m_prescaler_value, m_period_value);
                    end
                end else begin
                    expected = expected_settings.pop_front();
                    if (m_ok !== expected.ok || m_prescaler_value !== expected.prescaler ||
                        m_period_value !== expected.period) begin
                        failure_count++;
                        if (failure_count <= REPORT_LIMIT) begin
                            $display({"%0t: expected ok=%0d prescaler=%0d period=%0d, ",
                                      "got ok=%0d prescaler=%0d period=%0d"},
                                     $time, expected.ok, expected.prescaler, expected.period,
                                     m_ok, m_prescaler_value, m_period_value);
                        end
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_CLOCK_HZ: begin
                        clock_hz_q = cfg_wdata[CLOCK_W-1:0];
                    end
                    CFG_CLOCK_DIVIDER: begin
                        clock_divider_q = cfg_wdata[LIMIT_W-1:0];
                    end
                    CFG_PRESCALER_LIMIT: begin
                        prescaler_limit_q = cfg_wdata[LIMIT_W-1:0];
                    end
                    CFG_PERIOD_LIMIT: begin
                        period_limit_q = cfg_wdata[LIMIT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending_settings = expected_settings.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer prescaler and period calculator testbench
// Drives frequency requests under several clock and limit settings, first a
// directed set of corner cases and then random requests with random idle
// cycles on both channels and one long receiver hold-off. A side checker
// predicts every setting; the run fails on any mismatch or on a stall.
// ----------------------------------------------------------------------------
module testbench;
    import tppc_pkg::*;

    localparam int RESET_CYCLES        = 9;
    localparam int RANDOM_PHASES       = 12;
    localparam int REQUESTS_PER_PHASE  = 78;
    localparam int HOLD_OFF_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT      = 5000;
    localparam int PHASE_SETTLE_CYCLES = 4;
    localparam int FINAL_SETTLE_CYCLES = 120;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_CLOCK_HZ;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [FREQ_W-1:0]     s_target_frequency = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_ok;
    logic [LIMIT_W-1:0]    m_prescaler_value;
    logic [LIMIT_W-1:0]    m_period_value;

    int failure_count;
    int pending_settings;
    int quiet_cycles = 0;
    bit source_gaps_on = 1'b1;
    bit sink_stalls_on = 1'b1;
    bit hold_off_pending = 1'b0;

    logic [FREQ_W-1:0] corner_frequencies [12] = '{
        32'd0, 32'd1, 32'd2, 32'd1220, 32'd1221, 32'd80000000, 32'd80000001,
        32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
    };

    timer_prescaler_period_calc uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_target_frequency (s_target_frequency),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_ok               (m_ok),
        .m_prescaler_value  (m_prescaler_value),
        .m_period_value     (m_period_value)
    );

    timer_setting_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_target_frequency (s_target_frequency),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_ok               (m_ok),
        .m_prescaler_value  (m_prescaler_value),
        .m_period_value     (m_period_value),
        .failure_count      (failure_count),
        .pending_settings   (pending_settings)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_ready <= (sink_stalls_on && $urandom_range(99) < 30) ? 1'b0 : 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_frequency(input logic [FREQ_W-1:0] freq);
        if (source_gaps_on && $urandom_range(99) < 30) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 130)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_target_frequency <= freq;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results(input int settle_cycles);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_settings != 0);
        repeat (settle_cycles) @(posedge aclk);
    endtask

    task automatic write_timer_config(input logic [CFG_DATA_W-1:0] clock_word,
                                      input logic [CFG_DATA_W-1:0] divider_word,
                                      input logic [CFG_DATA_W-1:0] prescaler_word,
                                      input logic [CFG_DATA_W-1:0] period_word);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CLOCK_HZ;
        cfg_wdata <= clock_word;
        @(posedge aclk);
        cfg_index <= CFG_CLOCK_DIVIDER;
        cfg_wdata <= divider_word;
        @(posedge aclk);
        cfg_index <= CFG_PRESCALER_LIMIT;
        cfg_wdata <= prescaler_word;
        @(posedge aclk);
        cfg_index <= CFG_PERIOD_LIMIT;
        cfg_wdata <= period_word;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] clock_word;
        logic [CFG_DATA_W-1:0] divider_word;
        logic [CFG_DATA_W-1:0] prescaler_word;
        logic [CFG_DATA_W-1:0] period_word;
        logic [FREQ_W-1:0]     freq;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The reset configuration is exercised before any register is written.
        foreach (corner_frequencies[i]) begin
            send_frequency(corner_frequencies[i]);
        end
        drain_results(PHASE_SETTLE_CYCLES);

        write_timer_config(32'd0, 32'd65535, 32'd65535, 32'd0);
        send_frequency(32'd1);
        send_frequency(32'hFFFF_FFFF);
        drain_results(PHASE_SETTLE_CYCLES);

        write_timer_config(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
        send_frequency(32'd1);
        send_frequency(32'hFFFF_FFFF);
        drain_results(PHASE_SETTLE_CYCLES);

        write_timer_config(32'hFFFF_FFFF, 32'd0, 32'd65535, 32'd1);
        send_frequency(32'd1);
        send_frequency(32'd3);
        drain_results(PHASE_SETTLE_CYCLES);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 7))
                0: clock_word = 32'd1;
                1: clock_word = 32'hFFFF_FFFF;
                2: clock_word = 32'd80000000;
                3: clock_word = 32'd0;
                default: clock_word = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0, 1: divider_word = 32'd0;
                2: divider_word = 32'd65535;
                3: divider_word = $urandom_range(0, 65535);
                default: divider_word = $urandom_range(1, 15);
            endcase
            case ($urandom_range(0, 4))
                0: prescaler_word = 32'd0;
                1: prescaler_word = 32'd65535;
                2: prescaler_word = $urandom_range(0, 255);
                default: prescaler_word = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 7))
                0: period_word = 32'd65535;
                1: period_word = 32'd1;
                2: period_word = 32'd0;
                3, 4: period_word = $urandom_range(2, 255);
                default: period_word = $urandom_range(0, 65535);
            endcase
            // The upper bits of the narrow registers carry random junk.
            divider_word = ($urandom & 32'hFFFF_0000) | divider_word;
            prescaler_word = ($urandom & 32'hFFFF_0000) | prescaler_word;
            period_word = ($urandom & 32'hFFFF_0000) | period_word;
            write_timer_config(clock_word, divider_word, prescaler_word, period_word);

            source_gaps_on = (phase != 4);
            sink_stalls_on = (phase != 4);
            hold_off_pending = (phase == 7);

            repeat (REQUESTS_PER_PHASE) begin
                case ($urandom_range(0, 9))
                    0: freq = '0;
                    1, 2: freq = $urandom;
                    default: freq = $urandom >> $urandom_range(0, 31);
                endcase
                send_frequency(freq);
            end
            drain_results(PHASE_SETTLE_CYCLES);
        end

        drain_results(FINAL_SETTLE_CYCLES);
        if (failure_count == 0 && pending_settings == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
